// ===== design/lav_pkg.sv =====
`default_nettype none

package lav_pkg;

	// Field formats
	typedef logic signed [31:0] fix_t;
	typedef logic signed [63:0] wide_t;

	// Configuration register indexes
	localparam logic [1:0] RegUpX = 2'd0;
	localparam logic [1:0] RegUpY = 2'd1;
	localparam logic [1:0] RegUpZ = 2'd2;

	// Axis codes on the result channel
	localparam logic [1:0] AxisX = 2'd0;
	localparam logic [1:0] AxisY = 2'd1;
	localparam logic [1:0] AxisZ = 2'd2;

	localparam fix_t UpXReset = 32'sd0;
	localparam fix_t UpYReset = 32'sd65536;
	localparam fix_t UpZReset = 32'sd0;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned LzcSteps   = 6;
	localparam int unsigned RootSteps  = 32;
	localparam int unsigned QuotBits   = 32;
	localparam int unsigned CrossProds = 6;
	localparam int unsigned TransProds = 9;

	localparam logic [31:0] OneQ30 = 32'h4000_0000;

	// One classified input item as it waits in the front queue
	typedef struct packed {
		fix_t               cam_x;
		fix_t               cam_y;
		fix_t               cam_z;
		logic signed [32:0] dif_x;
		logic signed [32:0] dif_y;
		logic signed [32:0] dif_z;
		logic               zero_len;
	} view_item_t;

	typedef struct packed {
		logic  start;
		wide_t vec_x;
		wide_t vec_y;
		wide_t vec_z;
	} norm_req_t;

	typedef struct packed {
		logic done;
		logic ok;
		fix_t unit_x;
		fix_t unit_y;
		fix_t unit_z;
	} norm_rsp_t;

endpackage

`default_nettype wire

// ===== design/lav_front.sv =====
`default_nettype none

module lav_front import lav_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire fix_t       camera_x,
	input  wire fix_t       camera_y,
	input  wire fix_t       camera_z,
	input  wire fix_t       target_x,
	input  wire fix_t       target_y,
	input  wire fix_t       target_z,
	output logic            item_valid,
	output view_item_t      item,
	input  wire logic       item_pop
);

	view_item_t slot_q [QueueDepth];
	view_item_t item_new;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	// Form the view difference and flag a zero-length view direction
	always_comb begin
		item_new.cam_x    = camera_x;
		item_new.cam_y    = camera_y;
		item_new.cam_z    = camera_z;
		item_new.dif_x    = 33'(camera_x) - 33'(target_x);
		item_new.dif_y    = 33'(camera_y) - 33'(target_y);
		item_new.dif_z    = 33'(camera_z) - 33'(target_z);
		item_new.zero_len = (camera_x == target_x) && (camera_y == target_y) &&
			(camera_z == target_z);
	end

	assign in_ready   = (count_q != 2'(QueueDepth));
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_new;
		end
	end

endmodule

`default_nettype wire

// ===== design/lav_norm.sv =====
`default_nettype none

module lav_norm import lav_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire norm_req_t req,
	output norm_rsp_t      rsp
);

	typedef enum logic [7:0] {
		N_IDLE  = 8'b0000_0001,
		N_LZC   = 8'b0000_0010,
		N_SCALE = 8'b0000_0100,
		N_SQ    = 8'b0000_1000,
		N_ROOT  = 8'b0001_0000,
		N_ROUND = 8'b0010_0000,
		N_DIV   = 8'b0100_0000,
		N_DONE  = 8'b1000_0000
	} norm_state_t;

	norm_state_t state_q;
	logic [5:0]  cnt_q;
	logic        ok_q;

	wide_t       vin [3];
	logic [63:0] mag_new [3];
	logic [63:0] mag_q [3];
	logic        neg_q [3];
	logic [63:0] w_q;
	logic [6:0]  len_acc_q;
	logic [6:0]  lzc_sh;
	logic [6:0]  len;
	logic [6:0]  rsh;
	logic [63:0] rnd;
	logic [31:0] sc_new [3];
	logic [31:0] sc_q [3];
	logic [31:0] sq_op;
	logic [63:0] sq_s1;
	logic        sq_v_s1;
	logic [63:0] sum_q;
	logic [63:0] rv_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] root_try;
	logic [32:0] r_new;
	logic [32:0] r_q;
	logic [63:0] num_new [3];
	logic [34:0] rem_q [3];
	logic [31:0] num_q [3];
	logic [31:0] quo_q [3];
	logic [34:0] div_try [3];
	logic [31:0] q_clamp [3];
	fix_t        unit [3];

	function automatic logic [63:0] mag_of(input wide_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	assign vin[0] = req.vec_x;
	assign vin[1] = req.vec_y;
	assign vin[2] = req.vec_z;

	assign lzc_sh   = 7'd32 >> cnt_q[2:0];
	assign len      = len_acc_q + 7'd1;
	assign rsh      = len - 7'd31;
	assign rnd      = 64'd1 << (rsh - 7'd1);
	assign sq_op    = sc_q[cnt_q[1:0]];
	assign root_try = res_q + bit_q;
	assign r_new    = 33'(res_q) + 33'(rv_q > res_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_new[i] = mag_of(vin[i]);
			// bring the largest magnitude to 31 bits (32 if rounding carries), round half up when narrowing
			if (len > 7'd31) begin
				sc_new[i] = 32'((mag_q[i] + rnd) >> rsh);
			end else begin
				sc_new[i] = 32'(mag_q[i] << (7'd31 - len));
			end
			num_new[i] = ({32'd0, sc_q[i]} << 30) + 64'(r_new >> 1);
			div_try[i] = {rem_q[i][33:0], num_q[i][31]};
			q_clamp[i] = (quo_q[i] > OneQ30) ? OneQ30 : quo_q[i];
			unit[i]    = neg_q[i] ? -fix_t'(q_clamp[i]) : fix_t'(q_clamp[i]);
		end
	end

	assign rsp.done   = (state_q == N_DONE);
	assign rsp.ok     = ok_q;
	assign rsp.unit_x = unit[0];
	assign rsp.unit_y = unit[1];
	assign rsp.unit_z = unit[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= 6'd0;
			ok_q    <= 1'b0;
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= (state_q == N_SQ) && (cnt_q < 6'd3);
			unique case (state_q)
				N_IDLE: begin
					cnt_q <= 6'd0;
					if (req.start) begin
						if ((mag_new[0] | mag_new[1] | mag_new[2]) == 64'd0) begin
							ok_q    <= 1'b0;
							state_q <= N_DONE;
						end else begin
							ok_q    <= 1'b1;
							state_q <= N_LZC;
						end
					end
				end
				N_LZC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(LzcSteps - 1)) begin
						state_q <= N_SCALE;
					end
				end
				N_SCALE: begin
					cnt_q   <= 6'd0;
					state_q <= N_SQ;
				end
				N_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						cnt_q   <= 6'd0;
						state_q <= N_ROOT;
					end
				end
				N_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(RootSteps)) begin
						state_q <= N_ROUND;
					end
				end
				N_ROUND: begin
					cnt_q   <= 6'd0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(QuotBits - 1)) begin
						state_q <= N_DONE;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_new[i];
					neg_q[i] <= vin[i][63];
				end
				// bit length of the largest magnitude equals that of the OR
				w_q       <= mag_new[0] | mag_new[1] | mag_new[2];
				len_acc_q <= 7'd0;
			end
			N_LZC: begin
				if ((w_q >> lzc_sh) != 64'd0) begin
					w_q       <= w_q >> lzc_sh;
					len_acc_q <= len_acc_q + lzc_sh;
				end
			end
			N_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					sc_q[i] <= sc_new[i];
				end
				sum_q <= 64'd0;
			end
			N_ROOT: begin
				if (cnt_q == 6'd0) begin
					rv_q  <= sum_q;
					res_q <= 64'd0;
					bit_q <= 64'd1 << 62;
				end else begin
					if (rv_q >= root_try) begin
						rv_q  <= rv_q - root_try;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			N_ROUND: begin
				r_q <= r_new;
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= 35'(num_new[i] >> 32);
					num_q[i] <= num_new[i][31:0];
					quo_q[i] <= 32'd0;
				end
			end
			N_DIV: begin
				for (int i = 0; i < 3; i++) begin
					num_q[i] <= num_q[i] << 1;
					if (div_try[i] >= {2'b00, r_q}) begin
						rem_q[i] <= div_try[i] - {2'b00, r_q};
						quo_q[i] <= {quo_q[i][30:0], 1'b1};
					end else begin
						rem_q[i] <= div_try[i];
						quo_q[i] <= {quo_q[i][30:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
		sq_s1 <= sq_op * sq_op;
		if (sq_v_s1) begin
			sum_q <= sum_q + sq_s1;
		end
	end

endmodule

`default_nettype wire

// ===== design/lav_back.sv =====
`default_nettype none

module lav_back import lav_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire view_item_t item,
	output logic            item_pop,
	input  wire fix_t       up_x,
	input  wire fix_t       up_y,
	input  wire fix_t       up_z,
	output norm_req_t       norm_req,
	input  wire norm_rsp_t  norm_rsp,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      axis_index,
	output fix_t            comp_x,
	output fix_t            comp_y,
	output fix_t            comp_z,
	output fix_t            translation,
	output logic            degenerate,
	output logic            last
);

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_NZ   = 8'b0000_0010,
		B_CX   = 8'b0000_0100,
		B_NX   = 8'b0000_1000,
		B_CY   = 8'b0001_0000,
		B_NY   = 8'b0010_0000,
		B_TR   = 8'b0100_0000,
		B_EMIT = 8'b1000_0000
	} back_state_t;

	back_state_t state_q;
	logic [3:0]  cnt_q;
	logic        start_q;
	logic        bad_q;
	logic [1:0]  emit_k_q;

	fix_t  cam_q [3];
	fix_t  axz_q [3];
	fix_t  axx_q [3];
	fix_t  axy_q [3];
	fix_t  up_v [3];
	fix_t  unit_v [3];
	wide_t acc_q [3];

	fix_t       a_vec [3];
	fix_t       b_vec [3];
	logic [1:0] ia;
	logic [1:0] ib;
	logic [1:0] sel_j;
	logic       sel_first;
	logic       sel_last;
	logic       in_cross;
	logic       issue;
	fix_t       op_a;
	fix_t       op_b;

	wide_t      p_s1;
	logic       pv_s1;
	logic [1:0] pj_s1;
	logic       pfirst_s1;
	logic       psub_s1;
	logic       plast_s1;

	logic       out_valid_q;
	logic [1:0] axis_index_q;
	fix_t       comp_x_q;
	fix_t       comp_y_q;
	fix_t       comp_z_q;
	fix_t       translation_q;
	logic       degenerate_q;
	logic       last_q;
	logic       out_load;
	fix_t       emit_v [3];
	fix_t       emit_tr;

	// Negate, round half up on the magnitude at bit 30, saturate to Q16.16
	function automatic fix_t trans_sat(input wide_t sum);
		wide_t       neg;
		logic [63:0] mg;
		logic [34:0] rq;
		neg = -sum;
		mg  = neg[63] ? 64'(-neg) : 64'(neg);
		rq  = 35'((mg + (64'd1 << 29)) >> 30);
		if (!neg[63]) begin
			return (rq > 35'h0_7FFF_FFFF) ? fix_t'(32'h7FFF_FFFF) : fix_t'(rq[31:0]);
		end
		return (rq > 35'h0_8000_0000) ? fix_t'(32'h8000_0000) : fix_t'(32'(35'd0 - rq));
	endfunction

	assign up_v[0]   = up_x;
	assign up_v[1]   = up_y;
	assign up_v[2]   = up_z;
	assign unit_v[0] = norm_rsp.unit_x;
	assign unit_v[1] = norm_rsp.unit_y;
	assign unit_v[2] = norm_rsp.unit_z;

	assign item_pop = (state_q == B_IDLE) && item_valid;

	assign norm_req.start = start_q;
	assign norm_req.vec_x = acc_q[0];
	assign norm_req.vec_y = acc_q[1];
	assign norm_req.vec_z = acc_q[2];

	assign in_cross = (state_q == B_CX) || (state_q == B_CY);
	assign issue    = (in_cross && (cnt_q < 4'(CrossProds))) ||
		((state_q == B_TR) && (cnt_q < 4'(TransProds)));

	// Product schedule for the shared multiplier
	always_comb begin
		ia        = 2'd0;
		ib        = 2'd0;
		sel_j     = 2'd0;
		sel_first = 1'b0;
		sel_last  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a_vec[i] = up_v[i];
			b_vec[i] = axz_q[i];
		end
		if (in_cross) begin
			if (state_q == B_CY) begin
				for (int i = 0; i < 3; i++) begin
					a_vec[i] = axz_q[i];
					b_vec[i] = axx_q[i];
				end
			end
			unique case (cnt_q)
				4'd0: begin ia = 2'd1; ib = 2'd2; sel_j = 2'd0; sel_first = 1'b1; end
				4'd1: begin ia = 2'd2; ib = 2'd1; sel_j = 2'd0; end
				4'd2: begin ia = 2'd2; ib = 2'd0; sel_j = 2'd1; sel_first = 1'b1; end
				4'd3: begin ia = 2'd0; ib = 2'd2; sel_j = 2'd1; end
				4'd4: begin ia = 2'd0; ib = 2'd1; sel_j = 2'd2; sel_first = 1'b1; end
				4'd5: begin ia = 2'd1; ib = 2'd0; sel_j = 2'd2; sel_last = 1'b1; end
				default: begin end
			endcase
		end else begin
			unique case (cnt_q)
				4'd0: begin sel_j = AxisX; ia = 2'd0; sel_first = 1'b1; end
				4'd1: begin sel_j = AxisX; ia = 2'd1; end
				4'd2: begin sel_j = AxisX; ia = 2'd2; end
				4'd3: begin sel_j = AxisY; ia = 2'd0; sel_first = 1'b1; end
				4'd4: begin sel_j = AxisY; ia = 2'd1; end
				4'd5: begin sel_j = AxisY; ia = 2'd2; end
				4'd6: begin sel_j = AxisZ; ia = 2'd0; sel_first = 1'b1; end
				4'd7: begin sel_j = AxisZ; ia = 2'd1; end
				4'd8: begin sel_j = AxisZ; ia = 2'd2; sel_last = 1'b1; end
				default: begin end
			endcase
			ib = ia;
			for (int i = 0; i < 3; i++) begin
				unique case (sel_j)
					AxisX:   a_vec[i] = axx_q[i];
					AxisY:   a_vec[i] = axy_q[i];
					default: a_vec[i] = axz_q[i];
				endcase
				b_vec[i] = cam_q[i];
			end
		end
	end

	assign op_a = a_vec[ia];
	assign op_b = b_vec[ib];

	// Result for the current emit slot
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unique case (emit_k_q)
				AxisX:   emit_v[i] = axx_q[i];
				AxisY:   emit_v[i] = axy_q[i];
				default: emit_v[i] = axz_q[i];
			endcase
			if (bad_q) begin
				emit_v[i] = 32'sd0;
			end
		end
		emit_tr = bad_q ? 32'sd0 : trans_sat(acc_q[emit_k_q]);
	end

	assign out_load = (state_q == B_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= 4'd0;
			start_q     <= 1'b0;
			bad_q       <= 1'b0;
			emit_k_q    <= 2'd0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			pv_s1   <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					emit_k_q <= 2'd0;
					cnt_q    <= 4'd0;
					if (item_valid) begin
						if (item.zero_len) begin
							bad_q   <= 1'b1;
							state_q <= B_EMIT;
						end else begin
							bad_q   <= 1'b0;
							start_q <= 1'b1;
							state_q <= B_NZ;
						end
					end
				end
				B_NZ, B_NX, B_NY: begin
					cnt_q <= 4'd0;
					if (norm_rsp.done) begin
						if (!norm_rsp.ok) begin
							bad_q   <= 1'b1;
							state_q <= B_EMIT;
						end else if (state_q == B_NZ) begin
							state_q <= B_CX;
						end else if (state_q == B_NX) begin
							state_q <= B_CY;
						end else begin
							state_q <= B_TR;
						end
					end
				end
				B_CX, B_CY: begin
					if (pv_s1 && plast_s1) begin
						start_q <= 1'b1;
						state_q <= (state_q == B_CX) ? B_NX : B_NY;
					end
				end
				B_TR: begin
					if (pv_s1 && plast_s1) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_load) begin
						emit_k_q <= emit_k_q + 2'd1;
						if (emit_k_q == AxisZ) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_s1      <= 64'(op_a) * 64'(op_b);
		pj_s1     <= sel_j;
		pfirst_s1 <= sel_first;
		psub_s1   <= in_cross;
		plast_s1  <= sel_last;
		if (item_pop) begin
			cam_q[0] <= item.cam_x;
			cam_q[1] <= item.cam_y;
			cam_q[2] <= item.cam_z;
			acc_q[0] <= 64'(item.dif_x);
			acc_q[1] <= 64'(item.dif_y);
			acc_q[2] <= 64'(item.dif_z);
		end else if (pv_s1) begin
			if (pfirst_s1) begin
				acc_q[pj_s1] <= p_s1;
			end else if (psub_s1) begin
				acc_q[pj_s1] <= acc_q[pj_s1] - p_s1;
			end else begin
				acc_q[pj_s1] <= acc_q[pj_s1] + p_s1;
			end
		end
		if (norm_rsp.done && norm_rsp.ok) begin
			for (int i = 0; i < 3; i++) begin
				if (state_q == B_NZ) begin
					axz_q[i] <= unit_v[i];
				end
				if (state_q == B_NX) begin
					axx_q[i] <= unit_v[i];
				end
				if (state_q == B_NY) begin
					axy_q[i] <= unit_v[i];
				end
			end
		end
		if (out_load) begin
			axis_index_q  <= emit_k_q;
			comp_x_q      <= emit_v[0];
			comp_y_q      <= emit_v[1];
			comp_z_q      <= emit_v[2];
			translation_q <= emit_tr;
			degenerate_q  <= bad_q;
			last_q        <= (emit_k_q == AxisZ);
		end
	end

	assign out_valid   = out_valid_q;
	assign axis_index  = axis_index_q;
	assign comp_x      = comp_x_q;
	assign comp_y      = comp_y_q;
	assign comp_z      = comp_z_q;
	assign translation = translation_q;
	assign degenerate  = degenerate_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ===== design/look_at_view_matrix.sv =====
// Look-at view basis: three result beats (x, y, z axis) per input beat.
// The rate of input beats is set by the shared normalize unit (three normalizations
// per item, each a 32-step root and a 32-step divide); while it has a free slot, the
// front queue accepts a new input beat before an earlier item is through.
// Reset (arst_n low): queues and sequencers empty, up vector back to (0, 1.0, 0).
`default_nettype none

module look_at_view_matrix import lav_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire fix_t       cfg_data,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire fix_t       camera_x,
	input  wire fix_t       camera_y,
	input  wire fix_t       camera_z,
	input  wire fix_t       target_x,
	input  wire fix_t       target_y,
	input  wire fix_t       target_z,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      axis_index,
	output fix_t            comp_x,
	output fix_t            comp_y,
	output fix_t            comp_z,
	output fix_t            translation,
	output logic            degenerate,
	output logic            last
);

	// World up vector, Q16.16. Written by the user only while the block is idle; not enforced by the block.
	fix_t up_x_q;
	fix_t up_y_q;
	fix_t up_z_q;

	// Front to back: one classified item at a time out of a two-deep queue
	logic       item_valid;
	view_item_t item;
	logic       item_pop;

	// Back to normalize unit
	norm_req_t norm_req;
	norm_rsp_t norm_rsp;

	// Configuration writes are always accepted and registered straight into the up vector; drop indexes past up_z.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= UpXReset;
			up_y_q <= UpYReset;
			up_z_q <= UpZReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegUpX:  up_x_q <= cfg_data;
				RegUpY:  up_y_q <= cfg_data;
				RegUpZ:  up_z_q <= cfg_data;
				default: begin end
			endcase
		end
	end

	// Front: take input beats, form camera - target, flag camera == target.
	// Its queue keeps accepting, until both slots are full, while the back is busy on an earlier item.
	lav_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.camera_x   (camera_x),
		.camera_y   (camera_y),
		.camera_z   (camera_z),
		.target_x   (target_x),
		.target_y   (target_y),
		.target_z   (target_z),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// Back: normalize z, cross up x z, normalize x, cross z x, normalize y,
	// then the three translations, the products all through one 32x32
	// multiplier. A degenerate item skips ahead to three zero beats with the
	// flag set. Results leave through an output register, so the back moves on
	// to the next item while the last beat still waits for out_ready.
	lav_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.up_x        (up_x_q),
		.up_y        (up_y_q),
		.up_z        (up_z_q),
		.norm_req    (norm_req),
		.norm_rsp    (norm_rsp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.axis_index  (axis_index),
		.comp_x      (comp_x),
		.comp_y      (comp_y),
		.comp_z      (comp_z),
		.translation (translation),
		.degenerate  (degenerate),
		.last        (last)
	);

	// Normalize unit: leading-one search, scale to 31 bits, sum of squares,
	// bit-serial square root, then three bit-serial divides in parallel lanes.
	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (norm_req),
		.rsp    (norm_rsp)
	);

endmodule

`default_nettype wire

// ===== bench/look_at_view_matrix_tb.sv =====
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
	import lav_pkg::*;

	// Index past the last register: the block must drop such a write
	localparam logic [1:0] RegSpare = 2'd3;
	localparam int unsigned CycleLimit = 2_000_000;

	typedef longint trip_t [0:2];

	// One expected result beat
	typedef struct {
		logic [1:0] axis;
		fix_t       cx;
		fix_t       cy;
		fix_t       cz;
		fix_t       tr;
		logic       degen;
		logic       tail;
	} axis_beat_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	fix_t       cfg_data;
	logic       in_valid;
	logic       in_ready;
	fix_t       camera_x, camera_y, camera_z;
	fix_t       target_x, target_y, target_z;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] axis_index;
	fix_t       comp_x, comp_y, comp_z, translation;
	logic       degenerate;
	logic       last;

	axis_beat_t basis_q[$];     // expected beats, oldest first
	fix_t       up_shadow [0:2]; // our copy of the world up registers
	int         errors;
	int         views_sent;
	int         beats_seen;
	int         degen_seen;
	int unsigned cycles;
	bit         calm;            // no idling on either side when set

	look_at_view_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.camera_x(camera_x), .camera_y(camera_y), .camera_z(camera_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.axis_index(axis_index), .comp_x(comp_x), .comp_y(comp_y),
		.comp_z(comp_z), .translation(translation),
		.degenerate(degenerate), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Basis predictor
	// ------------------------------------------------------------------

	// Bitwise integer square root (floor)
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Scale v to a Q2.30 unit vector; returns 0 when v is all zero
	function automatic bit unit_vec(input trip_t v, output trip_t u);
		logic [63:0] a [0:2];
		logic [63:0] m, s, r, q;
		int len, k;
		m = 0;
		s = 0;
		u[0] = 0; u[1] = 0; u[2] = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
			if (a[i] > m)
				m = a[i];
		end
		if (m == 0)
			return 1'b0;
		len = 0;
		while (len < 64 && (m >> len) != 0)
			len++;
		// bring the largest magnitude to 31 bits (32 if rounding carries)
		for (int i = 0; i < 3; i++) begin
			if (len > 31) begin
				k = len - 31;
				a[i] = (a[i] + (64'd1 << (k - 1))) >> k;
			end else if (len < 31) begin
				a[i] = a[i] << (31 - len);
			end
			s = s + a[i] * a[i];
		end
		r = floor_root(s);
		if (s - r * r > r)
			r = r + 1;
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 30) + (r >> 1)) / r;
			if (q > 64'(OneQ30))
				q = 64'(OneQ30);
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void cross_of(input trip_t a, input trip_t b, output trip_t o);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// -dot(axis, camera) rounded from Q18.46 to Q16.16 and saturated
	function automatic fix_t shift_of(input trip_t ax, input trip_t cam);
		longint sum, t;
		logic [63:0] mg;
		sum = -(ax[0] * cam[0] + ax[1] * cam[1] + ax[2] * cam[2]);
		mg = ((sum < 0 ? 64'(-sum) : 64'(sum)) + (64'd1 << 29)) >> 30;
		t = sum < 0 ? -longint'(mg) : longint'(mg);
		if (t > 64'sh7FFF_FFFF)
			t = 64'sh7FFF_FFFF;
		if (t < -64'sh8000_0000)
			t = -64'sh8000_0000;
		return fix_t'(t);
	endfunction

	// Queue the three axis beats that one view causes
	task automatic predict_basis(input fix_t cx, cy, cz, tx, ty, tz);
		trip_t cam, dif, up, tmp, xa, ya, za;
		bit ok;
		axis_beat_t b;
		cam[0] = cx; cam[1] = cy; cam[2] = cz;
		dif[0] = longint'(cx) - longint'(tx);
		dif[1] = longint'(cy) - longint'(ty);
		dif[2] = longint'(cz) - longint'(tz);
		for (int i = 0; i < 3; i++)
			up[i] = up_shadow[i];
		ok = unit_vec(dif, za);
		if (ok) begin
			cross_of(up, za, tmp);
			ok = unit_vec(tmp, xa);
		end
		if (ok) begin
			cross_of(za, xa, tmp);
			ok = unit_vec(tmp, ya);
		end
		for (int k = 0; k < 3; k++) begin
			b.axis = k == 0 ? AxisX : (k == 1 ? AxisY : AxisZ);
			b.tail = (k == 2);
			b.degen = !ok;
			b.cx = 0; b.cy = 0; b.cz = 0; b.tr = 0;
			if (ok) begin
				if (k == 0)
					tmp = xa;
				else if (k == 1)
					tmp = ya;
				else
					tmp = za;
				b.cx = fix_t'(tmp[0]);
				b.cy = fix_t'(tmp[1]);
				b.cz = fix_t'(tmp[2]);
				b.tr = shift_of(tmp, cam);
			end
			basis_q.push_back(b);
		end
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Drive one view beat and hold it until the block takes it
	task automatic send_view(input fix_t cx, cy, cz, tx, ty, tz);
		if (!calm && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		camera_x <= cx; camera_y <= cy; camera_z <= cz;
		target_x <= tx; target_y <= ty; target_z <= tz;
		do @(posedge clk); while (!in_ready);
		predict_basis(cx, cy, cz, tx, ty, tz);
		views_sent++;
	endtask

	// Drain: drop valid and wait until every expected beat is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (basis_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input fix_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx != RegSpare)
			up_shadow[idx] = data;
	endtask

	// Only called with the block idle
	task automatic set_up(input fix_t ux, uy, uz);
		wait_idle();
		write_reg(RegUpX, ux);
		write_reg(RegUpY, uy);
		write_reg(RegUpZ, uz);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Full-range words half the time, otherwise values within +-8.0 or within +-32 LSB of the origin
	function automatic fix_t rand_fix();
		case ($urandom_range(3))
			0:       return fix_t'($urandom_range(0, 2 * 65536 * 8) - 65536 * 8);
			1:       return fix_t'($urandom_range(0, 64) - 32);
			default: return fix_t'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		fix_t cx, cy, cz;
		for (int n = 0; n < count; n++) begin
			cx = rand_fix(); cy = rand_fix(); cz = rand_fix();
			case ($urandom_range(15))
				// camera on the target: z collapses
				0:       send_view(cx, cy, cz, cx, cy, cz);
				// view straight along the current up direction
				1:       send_view(cx, cy, cz, cx - up_shadow[0], cy - up_shadow[1],
						cz - up_shadow[2]);
				default: send_view(cx, cy, cz, rand_fix(), rand_fix(), rand_fix());
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_default_up();
		send_view(0, 0, 32'sd327680, 0, 0, 0);
		send_view(32'sd65536, 32'sd131072, 32'sd196608, -32'sd65536, 0, 32'sd65536);
		send_view(1, 0, 0, 0, 0, 0);
		send_view(0, 0, 0, 0, 0, 1);
	endtask

	task automatic test_degenerate();
		// camera equals target
		send_view(32'sd12345, -32'sd777, 32'sd99, 32'sd12345, -32'sd777, 32'sd99);
		// looking straight up and straight down
		send_view(0, 32'sd65536, 0, 0, 0, 0);
		send_view(32'sd5, -32'sd400000, 32'sd5, 32'sd5, 32'sd400000, 32'sd5);
		// zero up vector: every view collapses
		set_up(0, 0, 0);
		send_view(0, 0, 32'sd65536, 0, 0, 0);
		send_view(32'sd70000, -32'sd3, 32'sd9, 0, 32'sd1, -32'sd8);
	endtask

	task automatic test_extremes();
		set_up(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_view(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_view(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_view(-32'sd1, -32'sd1, -32'sd1, 0, 0, 0);
		send_view(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0);
		set_up(32'sh8000_0000, 1, -32'sd1);
		send_view(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
		send_view(1, 1, 1, 0, 0, 0);
		// a write to the spare index must leave up untouched
		wait_idle();
		write_reg(RegSpare, 32'sh1234_5678);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_view(0, 0, 32'sd65536, 0, 0, 0);
		send_view(32'sd3, 32'sd3, 32'sd3, -32'sd3, 32'sd3, -32'sd3);
	endtask

	task automatic test_random_views();
		set_up(UpXReset, UpYReset, UpZReset);
		send_random(60);
		set_up(32'sd23170, 32'sd46341, -32'sd23170);
		send_random(60);
		set_up(fix_t'($urandom), fix_t'($urandom), fix_t'($urandom));
		send_random(60);
		set_up(0, 0, -32'sd1);
		send_random(30);
		// last stretch runs with both sides flat out
		set_up(fix_t'($urandom), 32'sd65536, fix_t'($urandom));
		calm = 1'b1;
		send_random(40);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	task automatic report(input string msg);
		$display("MISMATCH %s", msg);
		errors++;
	endtask

	task automatic report_field(input string what, input logic [31:0] got, want);
		report($sformatf("beat %0d %s: got %h expected %h", beats_seen, what, got, want));
	endtask

	// Receiver stalls in random bursts until the calm stretch
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	end

	// Compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (basis_q.size() == 0) begin
				report($sformatf("unexpected result beat, axis %0d", axis_index));
			end else begin
				axis_beat_t w;
				w = basis_q.pop_front();
				if (axis_index !== w.axis)
					report_field("axis_index", 32'(axis_index), 32'(w.axis));
				if (comp_x !== w.cx)        report_field("comp_x", comp_x, w.cx);
				if (comp_y !== w.cy)        report_field("comp_y", comp_y, w.cy);
				if (comp_z !== w.cz)        report_field("comp_z", comp_z, w.cz);
				if (translation !== w.tr)   report_field("translation", translation, w.tr);
				if (degenerate !== w.degen)
					report_field("degenerate", 32'(degenerate), 32'(w.degen));
				if (last !== w.tail)        report_field("last", 32'(last), 32'(w.tail));
				if (w.degen)
					degen_seen++;
			end
			beats_seen++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		views_sent = 0;
		beats_seen = 0;
		degen_seen = 0;
		cycles = 0;
		calm = 1'b0;
		up_shadow[0] = UpXReset;
		up_shadow[1] = UpYReset;
		up_shadow[2] = UpZReset;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegUpX;
		cfg_data = 0;
		in_valid = 1'b0;
		camera_x = 0; camera_y = 0; camera_z = 0;
		target_x = 0; target_y = 0; target_z = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_up();
		test_degenerate();
		test_extremes();
		test_random_views();

		// let the tail drain, then give the block a short grace period
		wait_idle();
		repeat (300) @(posedge clk);

		$display("Covered %0d views, %0d axis beats (%0d degenerate) over several up vectors",
			views_sent, beats_seen, degen_seen);
		if (basis_q.size() != 0)
			report($sformatf("%0d expected beats never arrived", basis_q.size()));
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
